/* hw/rtl/dlf_pkg.sv */
// dlf_pkg: shared types and constants for the dense layer forward block
// item, result and command structs, kind codes, queue depths, datapath widths
// no dependencies
`default_nettype none

package dlf_pkg;

   localparam int INDEX_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int IDX_LIMIT = 64;
   localparam int VALUE_W   = 16;
   localparam int PROD_W    = 32;
   localparam int ACC_W     = 38;
   localparam int SH_W      = ACC_W - 8;
   localparam int SUM_W     = SH_W + 1;
   localparam int CMD_DEPTH = 2;
   localparam int RES_DEPTH = 4;

   localparam logic [1:0] KIND_WEIGHT  = 2'd0;
   localparam logic [1:0] KIND_BIAS    = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   typedef struct packed {
      logic [1:0]                kind;
      logic [INDEX_W-1:0]        in_index;
      logic [INDEX_W-1:0]        out_index;
      logic signed [VALUE_W-1:0] value;
      logic                      vector_end;
   } req_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        neuron;
      logic signed [VALUE_W-1:0] activation;
      logic                      clipped;
      logic                      last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                op;
      logic                      wr_en;
      logic                      start;
      logic [INDEX_W-1:0]        in_index;
      logic [INDEX_W-1:0]        out_index;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last_term;
      logic               last_neuron;
      logic [INDEX_W-1:0] neuron;
   } tag_type;

endpackage

`default_nettype wire

/* hw/rtl/dense_layer_forward.sv */
// commands: accepted store and feature items pass through the command queue
// compute: one multiply-accumulate term per cycle while a result slot is free,
//   in_count*out_count terms in all, each count clamped to the store range
// stores and vector loads: one item per cycle while idle; results queue 4 deep
// reset: queues and sequencer cleared, in_count and out_count set to 64;
//   weight, bias and feature memories are not cleared
`default_nettype none

module dense_layer_forward #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_OUTPUTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   input  wire dlf_pkg::req_item_type req_data,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output dlf_pkg::rsp_item_type      rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [2:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   logic [dlf_pkg::COUNT_W-1:0]         in_cnt_ff, out_cnt_ff;
   logic                                csr_wr;
   logic                                cmd_valid, cmd_pop;
   logic [$bits(dlf_pkg::cmd_type)-1:0] cmd_bits;
   logic                                res_push, res_full, res_taken;
   dlf_pkg::rsp_item_type               res_data;
   logic [$bits(dlf_pkg::rsp_item_type)-1:0] rsp_bits;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= dlf_pkg::COUNT_W'(dlf_pkg::IDX_LIMIT);
         out_cnt_ff <= dlf_pkg::COUNT_W'(dlf_pkg::IDX_LIMIT);
      end else if (csr_wr) begin
         if (csr_paddr[2]) begin
            out_cnt_ff <= csr_pwdata[dlf_pkg::COUNT_W-1:0];
         end else begin
            in_cnt_ff <= csr_pwdata[dlf_pkg::COUNT_W-1:0];
         end
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'(out_cnt_ff) : 32'(in_cnt_ff);

   dlf_front #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd_bits  (cmd_bits),
      .cmd_pop   (cmd_pop)
   );

   dlf_back #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_OUTPUTS (MAX_OUTPUTS),
      .RES_DEPTH   (dlf_pkg::RES_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_bits  (cmd_bits),
      .cmd_pop   (cmd_pop),
      .in_count  (in_cnt_ff),
      .out_count (out_cnt_ff),
      .res_taken (res_taken),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   assign res_taken = rsp_pop && !rsp_empty;

   dlf_fifo #(
      .WIDTH ($bits(dlf_pkg::rsp_item_type)),
      .DEPTH (dlf_pkg::RES_DEPTH)
   ) u_res_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_data),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (rsp_bits),
      .empty   (rsp_empty)
   );

   assign rsp_data = dlf_pkg::rsp_item_type'(rsp_bits);

`ifndef ASSERT_OFF
   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dlf_fifo.sv */
// dlf_fifo: small register queue used between the front, back and result port
// depends on nothing
`default_nettype none

module dlf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/dlf_front.sv */
// dlf_front: accepts input items, drops those with no effect, queues commands
// depends on dlf_pkg and dlf_fifo
`default_nettype none

module dlf_front #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_OUTPUTS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   input  wire dlf_pkg::req_item_type               req_data,
   output logic                                     req_full,
   output logic                                     cmd_valid,
   output logic [$bits(dlf_pkg::cmd_type)-1:0]      cmd_bits,
   input  wire logic                                cmd_pop
);

   localparam int InLimit  = (MAX_INPUTS < dlf_pkg::IDX_LIMIT) ? MAX_INPUTS
                                                              : dlf_pkg::IDX_LIMIT;
   localparam int OutLimit = (MAX_OUTPUTS < dlf_pkg::IDX_LIMIT) ? MAX_OUTPUTS
                                                               : dlf_pkg::IDX_LIMIT;

   dlf_pkg::cmd_type cmd;
   logic             in_ok, out_ok, useful, cmd_empty;

   assign in_ok  = {1'b0, req_data.in_index} < dlf_pkg::COUNT_W'(InLimit);
   assign out_ok = {1'b0, req_data.out_index} < dlf_pkg::COUNT_W'(OutLimit);

   always_comb begin
      cmd.op        = req_data.kind;
      cmd.in_index  = req_data.in_index;
      cmd.out_index = req_data.out_index;
      cmd.value     = req_data.value;
      unique case (req_data.kind)
         dlf_pkg::KIND_WEIGHT: begin
            cmd.wr_en = in_ok && out_ok;
            cmd.start = 1'b0;
         end
         dlf_pkg::KIND_BIAS: begin
            cmd.wr_en = out_ok;
            cmd.start = 1'b0;
         end
         dlf_pkg::KIND_FEATURE: begin
            cmd.wr_en = in_ok;
            cmd.start = req_data.vector_end;
         end
         default: begin
            cmd.wr_en = 1'b0;
            cmd.start = 1'b0;
         end
      endcase
      useful = cmd.wr_en || cmd.start;
   end

   dlf_fifo #(
      .WIDTH ($bits(dlf_pkg::cmd_type)),
      .DEPTH (dlf_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push && useful),
      .wr_data (cmd),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd_bits),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

/* hw/rtl/dlf_back.sv */
// dlf_back: store writes and the multiply-accumulate sequencer
// holds weight, bias and feature memories; depends on dlf_pkg
`default_nettype none

module dlf_back #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_OUTPUTS = 64,
   parameter int RES_DEPTH   = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cmd_valid,
   input  wire logic [$bits(dlf_pkg::cmd_type)-1:0] cmd_bits,
   output logic                                     cmd_pop,
   input  wire logic [dlf_pkg::COUNT_W-1:0]         in_count,
   input  wire logic [dlf_pkg::COUNT_W-1:0]         out_count,
   input  wire logic                                res_taken,
   output logic                                     res_push,
   output dlf_pkg::rsp_item_type                    res_data
);

   localparam int InLimit  = (MAX_INPUTS < dlf_pkg::IDX_LIMIT) ? MAX_INPUTS
                                                              : dlf_pkg::IDX_LIMIT;
   localparam int OutLimit = (MAX_OUTPUTS < dlf_pkg::IDX_LIMIT) ? MAX_OUTPUTS
                                                               : dlf_pkg::IDX_LIMIT;
   localparam int IW    = (InLimit > 1) ? $clog2(InLimit) : 1;
   localparam int OW    = (OutLimit > 1) ? $clog2(OutLimit) : 1;
   localparam int CredW = $clog2(RES_DEPTH + 1);
   localparam int CW    = dlf_pkg::COUNT_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic signed [dlf_pkg::SUM_W-1:0] SatHi = dlf_pkg::SUM_W'(32'sd32767);
   localparam logic signed [dlf_pkg::SUM_W-1:0] SatLo = dlf_pkg::SUM_W'(-32'sd32768);

   dlf_pkg::cmd_type cmd;
   logic             state_ff, state_in;
   logic [IW-1:0]    i_ff, i_in;
   logic [OW-1:0]    j_ff, j_in;
   logic [IW-1:0]    nin_last_ff, nin_last_in;
   logic [OW-1:0]    nout_last_ff, nout_last_in;
   logic [CredW-1:0] credit_ff, credit_in;
   logic [CW-1:0]    in_eff_m1, out_eff_m1;
   logic             issue, new_neuron;

   logic [dlf_pkg::VALUE_W-1:0] w_mem    [2**(IW+OW)];
   logic [dlf_pkg::VALUE_W-1:0] bias_mem [2**OW];
   logic [dlf_pkg::VALUE_W-1:0] feat_mem [2**IW];

   logic signed [dlf_pkg::VALUE_W-1:0] x_rd_ff, w_rd_ff, b_rd_ff, b2_ff, b3_ff;
   logic signed [dlf_pkg::PROD_W-1:0]  prod_ff;
   logic signed [dlf_pkg::ACC_W-1:0]   acc_ff;
   logic signed [dlf_pkg::SH_W-1:0]    shifted;
   logic signed [dlf_pkg::SUM_W-1:0]   sum;
   dlf_pkg::tag_type                   s1_ff, s1_in, s2_ff, s3_ff;
   dlf_pkg::rsp_item_type              res_ff, res_in;
   logic                               res_push_ff;

   assign cmd = dlf_pkg::cmd_type'(cmd_bits);

   // effective counts minus one, saturated into the store range
   always_comb begin
      if (in_count == '0) begin
         in_eff_m1 = '0;
      end else if (in_count > CW'(InLimit)) begin
         in_eff_m1 = CW'(InLimit - 1);
      end else begin
         in_eff_m1 = in_count - 1'b1;
      end
      if (out_count == '0) begin
         out_eff_m1 = '0;
      end else if (out_count > CW'(OutLimit)) begin
         out_eff_m1 = CW'(OutLimit - 1);
      end else begin
         out_eff_m1 = out_count - 1'b1;
      end
   end

   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid;
   assign issue      = (state_ff == ST_RUN) && ((i_ff != '0) || (credit_ff != '0));
   assign new_neuron = issue && (i_ff == '0);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      nin_last_in  = nin_last_ff;
      nout_last_in = nout_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd.start) begin
               state_in     = ST_RUN;
               i_in         = '0;
               j_in         = '0;
               nin_last_in  = in_eff_m1[IW-1:0];
               nout_last_in = out_eff_m1[OW-1:0];
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (i_ff == nin_last_ff) begin
                  i_in = '0;
                  if (j_ff == nout_last_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
      endcase
      credit_in = credit_ff - CredW'(new_neuron) + CredW'(res_taken);
   end

   always_comb begin
      s1_in.valid       = issue;
      s1_in.first       = (i_ff == '0);
      s1_in.last_term   = (i_ff == nin_last_ff);
      s1_in.last_neuron = (j_ff == nout_last_ff);
      s1_in.neuron      = dlf_pkg::INDEX_W'(j_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         nin_last_ff  <= '0;
         nout_last_ff <= '0;
         credit_ff    <= CredW'(RES_DEPTH);
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         res_push_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         nin_last_ff  <= nin_last_in;
         nout_last_ff <= nout_last_in;
         credit_ff    <= credit_in;
         s1_ff        <= s1_in;
         s2_ff        <= s1_ff;
         s3_ff        <= s2_ff;
         res_push_ff  <= s3_ff.valid && s3_ff.last_term;
      end
   end

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.wr_en) begin
         unique case (cmd.op)
            dlf_pkg::KIND_WEIGHT: begin
               w_mem[{cmd.in_index[IW-1:0], cmd.out_index[OW-1:0]}] <= cmd.value;
            end
            dlf_pkg::KIND_BIAS: begin
               bias_mem[cmd.out_index[OW-1:0]] <= cmd.value;
            end
            dlf_pkg::KIND_FEATURE: begin
               feat_mem[cmd.in_index[IW-1:0]] <= cmd.value;
            end
            default: begin
            end
         endcase
      end
      x_rd_ff <= feat_mem[i_ff];
      w_rd_ff <= w_mem[{i_ff, j_ff}];
      b_rd_ff <= bias_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      prod_ff <= x_rd_ff * w_rd_ff;
      b2_ff   <= b_rd_ff;
      b3_ff   <= b2_ff;
      if (s2_ff.valid) begin
         acc_ff <= s2_ff.first ? dlf_pkg::ACC_W'(prod_ff)
                               : acc_ff + dlf_pkg::ACC_W'(prod_ff);
      end
      res_ff <= res_in;
   end

   // floor shift, bias add, saturation
   always_comb begin
      shifted           = acc_ff[dlf_pkg::ACC_W-1:8];
      sum               = dlf_pkg::SUM_W'(shifted) + dlf_pkg::SUM_W'(b3_ff);
      res_in.neuron     = s3_ff.neuron;
      res_in.last       = s3_ff.last_neuron;
      if (sum > SatHi) begin
         res_in.activation = 16'sh7fff;
         res_in.clipped    = 1'b1;
      end else if (sum < SatLo) begin
         res_in.activation = -16'sh8000;
         res_in.clipped    = 1'b1;
      end else begin
         res_in.activation = sum[dlf_pkg::VALUE_W-1:0];
         res_in.clipped    = 1'b0;
      end
   end

   assign res_push = res_push_ff;
   assign res_data = res_ff;

`ifndef ASSERT_OFF
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CredW'(RES_DEPTH))
      else $error("result credit above queue depth");

   a_push_has_slot: assert property (@(posedge clock) disable iff (reset)
      res_push_ff |-> (credit_ff != CredW'(RES_DEPTH)))
      else $error("result pushed without a reserved slot");

   a_push_follows_issue: assert property (@(posedge clock) disable iff (reset)
      res_push_ff |-> $past(issue && (i_ff == nin_last_ff), 4))
      else $error("result pushed without a final term issued");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (issue && (i_ff == nin_last_ff) && (j_ff == nout_last_ff)) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after last neuron");
`endif

endmodule

`default_nettype wire
